// ----- hdl/sw_alarm_pkg.sv -----
// types, codes and constants shared by the stopwatch with alarm
package sw_alarm_pkg;

	localparam int unsigned MAX_DIGITS_DEF = 11;
	localparam logic [31:0] INTERVAL_RESET = 32'd1000;

	localparam int MS_W      = 10;
	localparam int SEC_W     = 23;
	localparam int HOUR_W    = 11;
	localparam int MIN_W     = 6;
	localparam int REM_MIN_W = 27;

	localparam logic [MS_W-1:0]  MS_LAST     = 10'd999;
	// elapsed_ms wraps at 2^32, which is 4294967 s and 296 ms
	localparam logic [MS_W-1:0]  MS_AT_WRAP  = 10'd295;
	localparam logic [SEC_W-1:0] SEC_AT_WRAP = 23'd4294967;
	localparam logic [MIN_W-1:0] SIXTY_LAST  = 6'd59;

	// x / 60 for any 32-bit x is (x * DIV60_MAGIC) >> DIV60_SHIFT
	localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
	localparam int          DIV60_SHIFT = 37;
	localparam logic [31:0] SIXTY       = 32'd60;

	localparam logic [2:0] KIND_REPORT = 3'd0;
	localparam logic [2:0] KIND_ALARM  = 3'd1;
	localparam logic [2:0] KIND_PAUSE  = 3'd2;
	localparam logic [2:0] KIND_RESET  = 3'd3;
	localparam logic [2:0] KIND_SET    = 3'd4;

	localparam logic [7:0] CHAR_PAUSE = 8'h70;
	localparam logic [7:0] CHAR_RESET = 8'h72;
	localparam logic [7:0] CHAR_CLEAR = 8'h61;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	// everything one request produces, apart from the time left
	typedef struct packed {
		logic [2:0]        kind;
		logic              two;
		logic [HOUR_W-1:0] hours;
		logic [MIN_W-1:0]  minutes;
		logic [MIN_W-1:0]  seconds;
		logic              running;
		logic [31:0]       alarm_value;
	} res_hdr_t;

endpackage

// ----- hdl/stopwatch_with_alarm.sv -----
// stopwatch with status reports and a one-shot alarm
//
// Takes one request per cycle (tick or command character) while in_stall is low and
// updates the stopwatch state in the same cycle. Elapsed time is kept as running ms/s/min/h
// counters, so no divider sits in the tick path. Each request's results pass three
// registers (snapshot, 32x32 multiply for the divide by sixty of the time left,
// correction) and then leave one per cycle while out_stall is low. A tick that gives both
// a report and the alarm holds the last stage until both have left, so the input may stall.
// The interval register may be written at any time the block is idle; cfg_ready is
// always high.
module stopwatch_with_alarm
	import sw_alarm_pkg::*;
#(
	parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 op,
	input  logic [7:0]           char_code,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           kind,
	output logic [HOUR_W-1:0]    hours,
	output logic [MIN_W-1:0]     minutes,
	output logic [MIN_W-1:0]     seconds,
	output logic                 running,
	output logic [31:0]          alarm_value,
	output logic [REM_MIN_W-1:0] remain_minutes,
	output logic [MIN_W-1:0]     remain_seconds,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [31:0]          cfg_data
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

	// stopwatch state
	logic [31:0]       interval_q;
	logic [MS_W-1:0]   ms_q;
	logic [SEC_W-1:0]  sec_q;
	logic [HOUR_W-1:0] hh_q;
	logic [MIN_W-1:0]  mm_q;
	logic [MIN_W-1:0]  ss_q;
	logic [31:0]       since_q;
	logic              run_q;
	logic [31:0]       alarm_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       dv_q;

	logic [MS_W-1:0]   ms_d;
	logic [SEC_W-1:0]  sec_d;
	logic [HOUR_W-1:0] hh_d;
	logic [MIN_W-1:0]  mm_d;
	logic [MIN_W-1:0]  ss_d;
	logic [31:0]       since_d;
	logic              run_d;
	logic [31:0]       alarm_d;
	logic              done_d;
	logic [CNT_W-1:0]  cnt_d;
	logic [31:0]       dv_d;

	// pipeline
	logic                 v_s1, v_s2, v_s3, second_q;
	res_hdr_t             hdr_s1, hdr_s2, hdr_s3;
	logic [31:0]          rem_s1, rem_s2;
	logic [REM_MIN_W-1:0] quot_s2, rmin_s3;
	logic [MIN_W-1:0]     rsec_s3;

	logic en1, en2, en3, accept, pop;

	// tick helpers
	logic [MS_W-1:0]   t_ms;
	logic [SEC_W-1:0]  t_sec;
	logic [HOUR_W-1:0] t_hh;
	logic [MIN_W-1:0]  t_mm;
	logic [MIN_W-1:0]  t_ss;
	logic [31:0]       since_inc;
	logic [SEC_W-1:0]  s_new;
	logic [31:0]       s_new32;
	logic              do_report, do_alarm;
	logic [35:0]       dv_mul;
	logic              has_res;
	res_hdr_t          hdr_d;
	logic [31:0]       rem_d;
	logic [63:0]       prod;
	logic [31:0]       q60;
	logic              show_report;

	assign cfg_ready = 1'b1;

	// elapsed time one millisecond on
	always_comb begin
		t_ms  = ms_q + 1'b1;
		t_sec = sec_q;
		t_hh  = hh_q;
		t_mm  = mm_q;
		t_ss  = ss_q;
		if (sec_q == SEC_AT_WRAP && ms_q == MS_AT_WRAP) begin
			t_ms  = '0;
			t_sec = '0;
			t_hh  = '0;
			t_mm  = '0;
			t_ss  = '0;
		end else if (ms_q == MS_LAST) begin
			t_ms  = '0;
			t_sec = sec_q + 1'b1;
			if (ss_q == SIXTY_LAST) begin
				t_ss = '0;
				if (mm_q == SIXTY_LAST) begin
					t_mm = '0;
					t_hh = hh_q + 1'b1;
				end else begin
					t_mm = mm_q + 1'b1;
				end
			end else begin
				t_ss = ss_q + 1'b1;
			end
		end
	end

	assign since_inc = (since_q == '1) ? since_q : since_q + 32'd1;
	assign s_new     = run_q ? t_sec : sec_q;
	assign s_new32   = {{(32-SEC_W){1'b0}}, s_new};
	assign do_report = run_q && (since_inc >= interval_q);
	assign do_alarm  = (alarm_q != '0) && !done_q && (s_new32 >= alarm_q);
	assign dv_mul    = ({4'd0, dv_q} << 3) + ({4'd0, dv_q} << 1) + {32'd0, char_code[3:0]};

	always_comb begin
		ms_d    = ms_q;
		sec_d   = sec_q;
		hh_d    = hh_q;
		mm_d    = mm_q;
		ss_d    = ss_q;
		since_d = since_q;
		run_d   = run_q;
		alarm_d = alarm_q;
		done_d  = done_q;
		cnt_d   = cnt_q;
		dv_d    = dv_q;
		has_res = 1'b0;
		hdr_d   = '0;
		rem_d   = '0;
		if (!op) begin
			if (run_q) begin
				ms_d    = t_ms;
				sec_d   = t_sec;
				hh_d    = t_hh;
				mm_d    = t_mm;
				ss_d    = t_ss;
				since_d = do_report ? '0 : since_inc;
			end
			if (do_alarm) begin
				done_d = 1'b1;
			end
			has_res = do_report || do_alarm;
			hdr_d.kind = do_report ? KIND_REPORT : KIND_ALARM;
			hdr_d.two  = do_report && do_alarm;
			hdr_d.hours   = t_hh;
			hdr_d.minutes = t_mm;
			hdr_d.seconds = t_ss;
			// a zero alarm is never above the seconds, so the time left reads 0
			rem_d = (alarm_q > s_new32) ? alarm_q - s_new32 : '0;
		end else begin
			priority if (char_code == CHAR_PAUSE) begin
				run_d      = !run_q;
				since_d    = '0;
				has_res    = 1'b1;
				hdr_d.kind = KIND_PAUSE;
			end else if (char_code == CHAR_RESET) begin
				ms_d       = '0;
				sec_d      = '0;
				hh_d       = '0;
				mm_d       = '0;
				ss_d       = '0;
				run_d      = 1'b1;
				done_d     = 1'b0;
				has_res    = 1'b1;
				hdr_d.kind = KIND_RESET;
			end else if (char_code == CHAR_CLEAR) begin
				cnt_d = '0;
				dv_d  = '0;
			end else if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
				if (cnt_q < MAX_CNT) begin
					cnt_d = cnt_q + 1'b1;
					dv_d  = (|dv_mul[35:32]) ? '1 : dv_mul[31:0];
				end
			end else if (char_code == CHAR_LF || char_code == CHAR_CR) begin
				if (cnt_q != '0) begin
					alarm_d    = dv_q;
					done_d     = 1'b0;
					cnt_d      = '0;
					dv_d       = '0;
					has_res    = 1'b1;
					hdr_d.kind = KIND_SET;
				end
			end else begin
				has_res = 1'b0;
			end
		end
		hdr_d.running     = run_d;
		hdr_d.alarm_value = alarm_d;
		if (hdr_d.kind != KIND_REPORT) begin
			hdr_d.hours   = '0;
			hdr_d.minutes = '0;
			hdr_d.seconds = '0;
			rem_d         = '0;
		end
	end

	// flow control: every stage moves when the one after it can take it
	assign pop      = out_valid && !out_stall;
	assign en3      = !v_s3 || (pop && last);
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;
	assign accept   = in_valid && en1;

	assign prod = rem_s1 * DIV60_MAGIC;
	assign q60  = {{(32-REM_MIN_W){1'b0}}, quot_s2} * SIXTY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
			ms_q       <= '0;
			sec_q      <= '0;
			hh_q       <= '0;
			mm_q       <= '0;
			ss_q       <= '0;
			since_q    <= '0;
			run_q      <= 1'b1;
			alarm_q    <= '0;
			done_q     <= 1'b0;
			cnt_q      <= '0;
			dv_q       <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			second_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				interval_q <= cfg_data;
			end
			if (accept) begin
				ms_q    <= ms_d;
				sec_q   <= sec_d;
				hh_q    <= hh_d;
				mm_q    <= mm_d;
				ss_q    <= ss_d;
				since_q <= since_d;
				run_q   <= run_d;
				alarm_q <= alarm_d;
				done_q  <= done_d;
				cnt_q   <= cnt_d;
				dv_q    <= dv_d;
			end
			if (en1) begin
				v_s1 <= accept && has_res;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3     <= v_s2;
				second_q <= 1'b0;
			end else if (pop) begin
				second_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			hdr_s1 <= hdr_d;
			rem_s1 <= rem_d;
		end
		if (en2) begin
			hdr_s2  <= hdr_s1;
			rem_s2  <= rem_s1;
			quot_s2 <= prod[DIV60_SHIFT +: REM_MIN_W];
		end
		if (en3) begin
			hdr_s3  <= hdr_s2;
			rmin_s3 <= quot_s2;
			rsec_s3 <= rem_s2[MIN_W-1:0] - q60[MIN_W-1:0];
		end
	end

	// the second result of a request is always the alarm
	assign show_report    = !second_q && (hdr_s3.kind == KIND_REPORT);
	assign out_valid      = v_s3;
	assign kind           = second_q ? KIND_ALARM : hdr_s3.kind;
	assign hours          = show_report ? hdr_s3.hours : '0;
	assign minutes        = show_report ? hdr_s3.minutes : '0;
	assign seconds        = show_report ? hdr_s3.seconds : '0;
	assign remain_minutes = show_report ? rmin_s3 : '0;
	assign remain_seconds = show_report ? rsec_s3 : '0;
	assign running        = hdr_s3.running;
	assign alarm_value    = hdr_s3.alarm_value;
	assign last           = second_q || !hdr_s3.two;

	a_done_needs_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (alarm_q != '0))
		else $error("alarm marked fired with no alarm set");

	a_hms_match: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(hh_q) * 3600 + int'(mm_q) * 60 + int'(ss_q)) == int'(sec_q))
		else $error("h:m:s counters disagree with the seconds count");

	a_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (ms_q <= MS_LAST) && (ss_q <= SIXTY_LAST) && (mm_q <= SIXTY_LAST))
		else $error("time counter out of range");

	a_second_only_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && second_q) |-> hdr_s3.two)
		else $error("second result shown for a single-result request");

endmodule

// ----- dv/stopwatch_alarm_checker.sv -----
`timescale 1ns / 100ps
// checker for the stopwatch with alarm: predicts every result and compares it field by field
module stopwatch_alarm_checker
	import sw_alarm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 op,
	input  logic [7:0]           char_code,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [2:0]           kind,
	input  logic [HOUR_W-1:0]    hours,
	input  logic [MIN_W-1:0]     minutes,
	input  logic [MIN_W-1:0]     seconds,
	input  logic                 running,
	input  logic [31:0]          alarm_value,
	input  logic [REM_MIN_W-1:0] remain_minutes,
	input  logic [MIN_W-1:0]     remain_seconds,
	input  logic                 last,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [31:0]          cfg_data,
	output int                   fail_count,
	output int                   due_count,
	output int                   results_seen,
	output int                   alarms_seen
);

	typedef struct {
		logic [2:0]           kind;
		logic [HOUR_W-1:0]    hours;
		logic [MIN_W-1:0]     minutes;
		logic [MIN_W-1:0]     seconds;
		logic                 running;
		logic [31:0]          alarm_value;
		logic [REM_MIN_W-1:0] remain_minutes;
		logic [MIN_W-1:0]     remain_seconds;
		logic                 last;
	} sw_result_t;

	// own copy of the stopwatch state
	logic [31:0] interval_ms   = INTERVAL_RESET;
	logic [31:0] elapsed_ms    = '0;
	logic [31:0] since_rep_ms  = '0;
	logic        is_running    = 1'b1;
	logic [31:0] alarm_secs    = '0;
	logic        alarm_fired   = 1'b0;
	logic [3:0]  digits_typed  = '0;
	logic [31:0] typed_value   = '0;

	sw_result_t due_results[$];
	int         lines_shown = 0;

	task automatic log_fault(input string msg);
		fail_count++;
		if (lines_shown < 40)
			$display("mismatch at result %0d: %s", results_seen, msg);
		lines_shown++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			log_fault($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	function automatic sw_result_t blank_result(input logic [2:0] k);
		sw_result_t r;
		r.kind           = k;
		r.hours          = '0;
		r.minutes        = '0;
		r.seconds        = '0;
		r.running        = is_running;
		r.alarm_value    = alarm_secs;
		r.remain_minutes = '0;
		r.remain_seconds = '0;
		r.last           = 1'b0;
		return r;
	endfunction

	// advance the stopwatch by one request and queue what it should produce
	task automatic step_stopwatch(input logic is_cmd, input logic [7:0] ch);
		sw_result_t  r;
		sw_result_t  batch[$];
		logic [31:0] secs;
		logic [31:0] left;
		logic [63:0] wide;
		if (!is_cmd) begin
			if (is_running) begin
				elapsed_ms = elapsed_ms + 32'd1;
				if (since_rep_ms != '1)
					since_rep_ms = since_rep_ms + 32'd1;
				if (since_rep_ms >= interval_ms) begin
					secs = elapsed_ms / 32'd1000;
					since_rep_ms = '0;
					r = blank_result(KIND_REPORT);
					r.hours   = HOUR_W'(secs / 32'd3600);
					r.minutes = MIN_W'((secs % 32'd3600) / 32'd60);
					r.seconds = MIN_W'(secs % 32'd60);
					if (alarm_secs != 0) begin
						left = (alarm_secs > secs) ? alarm_secs - secs : 32'd0;
						r.remain_minutes = REM_MIN_W'(left / 32'd60);
						r.remain_seconds = MIN_W'(left % 32'd60);
					end
					batch.push_back(r);
				end
			end
			// runs even while paused
			if (alarm_secs != 0 && !alarm_fired && elapsed_ms / 32'd1000 >= alarm_secs) begin
				alarm_fired = 1'b1;
				batch.push_back(blank_result(KIND_ALARM));
			end
		end else if (ch == CHAR_PAUSE) begin
			is_running = !is_running;
			since_rep_ms = '0;
			batch.push_back(blank_result(KIND_PAUSE));
		end else if (ch == CHAR_RESET) begin
			elapsed_ms = '0;
			is_running = 1'b1;
			alarm_fired = 1'b0;
			batch.push_back(blank_result(KIND_RESET));
		end else if (ch == CHAR_CLEAR) begin
			digits_typed = '0;
			typed_value = '0;
		end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
			if (digits_typed < MAX_DIGITS_DEF) begin
				wide = {32'd0, typed_value} * 64'd10 + {56'd0, ch - CHAR_ZERO};
				digits_typed = digits_typed + 4'd1;
				typed_value = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
			end
		end else if (ch == CHAR_LF || ch == CHAR_CR) begin
			if (digits_typed != 0) begin
				alarm_secs = typed_value;
				alarm_fired = 1'b0;
				digits_typed = '0;
				typed_value = '0;
				batch.push_back(blank_result(KIND_SET));
			end
		end
		if (batch.size() > 0)
			batch[batch.size()-1].last = 1'b1;
		foreach (batch[i])
			due_results.push_back(batch[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sw_result_t want;
		if (!arst_n) begin
			interval_ms  = INTERVAL_RESET;
			elapsed_ms   = '0;
			since_rep_ms = '0;
			is_running   = 1'b1;
			alarm_secs   = '0;
			alarm_fired  = 1'b0;
			digits_typed = '0;
			typed_value  = '0;
			due_results.delete();
			due_count    = 0;
			fail_count   = 0;
			results_seen = 0;
			alarms_seen  = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				interval_ms = cfg_data;
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					log_fault($sformatf("kind %0d arrived with nothing due", kind));
				end else begin
					want = due_results.pop_front();
					check_field("kind", 32'(kind), 32'(want.kind));
					check_field("hours", 32'(hours), 32'(want.hours));
					check_field("minutes", 32'(minutes), 32'(want.minutes));
					check_field("seconds", 32'(seconds), 32'(want.seconds));
					check_field("running", 32'(running), 32'(want.running));
					check_field("alarm_value", alarm_value, want.alarm_value);
					check_field("remain_minutes", 32'(remain_minutes),
						32'(want.remain_minutes));
					check_field("remain_seconds", 32'(remain_seconds),
						32'(want.remain_seconds));
					check_field("last", 32'(last), 32'(want.last));
				end
				results_seen++;
				if (kind == KIND_ALARM)
					alarms_seen++;
			end
			if (in_valid && !in_stall)
				step_stopwatch(op, char_code);
			due_count = due_results.size();
		end
	end

endmodule

// ----- dv/tb_stopwatch_with_alarm.sv -----
`timescale 1ns / 100ps
// testbench top for the stopwatch with alarm: stimulus, flow control and verdict
module tb_stopwatch_with_alarm;
	import sw_alarm_pkg::*;

	localparam int PHASE_ITEMS = 270;
	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE      = 10;

	typedef enum {FLOW_FREE, FLOW_RANDOM, FLOW_PERIODIC, FLOW_SPARSE} stall_mode_t;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 in_valid       = 1'b0;
	logic                 in_stall;
	logic                 op             = 1'b0;
	logic [7:0]           char_code      = '0;
	logic                 out_valid;
	logic                 out_stall      = 1'b0;
	logic [2:0]           kind;
	logic [HOUR_W-1:0]    hours;
	logic [MIN_W-1:0]     minutes;
	logic [MIN_W-1:0]     seconds;
	logic                 running;
	logic [31:0]          alarm_value;
	logic [REM_MIN_W-1:0] remain_minutes;
	logic [MIN_W-1:0]     remain_seconds;
	logic                 last;
	logic                 cfg_valid      = 1'b0;
	logic                 cfg_ready;
	logic [31:0]          cfg_data       = '0;

	int fail_count;
	int due_count;
	int results_seen;
	int alarms_seen;

	// stimulus bookkeeping
	int burst_left    = 0;
	bit gaps_on       = 1'b1;
	int sent_total    = 0;
	int phase_sent    = 0;
	int settings_used = 1;
	bit guess_running = 1'b1;
	int run_ms        = 0;
	int quiet_cycles  = 0;

	stopwatch_with_alarm dut (.*);

	stopwatch_alarm_checker checker_i (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// receiver back-pressure, switching between a few patterns
	initial begin : receiver
		stall_mode_t mode;
		int          span;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 120);
			for (int k = 0; k < span; k++) begin
				@(negedge clk);
				unique case (mode)
					FLOW_FREE: out_stall = 1'b0;
					FLOW_RANDOM: out_stall = ($urandom_range(0, 2) == 0);
					FLOW_PERIODIC: out_stall = (k % 7) < 4;
					default: out_stall = ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(input logic is_cmd, input logic [7:0] ch);
		@(negedge clk);
		in_valid = 1'b1;
		op = is_cmd;
		char_code = ch;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_total++;
		phase_sent++;
		if (!is_cmd && guess_running)
			run_ms++;
		if (is_cmd && ch == CHAR_PAUSE)
			guess_running = !guess_running;
		if (is_cmd && ch == CHAR_RESET) begin
			guess_running = 1'b1;
			run_ms = 0;
		end
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (gaps_on) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat ($urandom_range(0, 5)) @(posedge clk);
			end
		end
	endtask

	task automatic send_char(input logic [7:0] ch);
		send_request(1'b1, ch);
	endtask

	task automatic tick_run(input int n);
		repeat (n) send_request(1'b0, 8'($urandom));
	endtask

	task automatic key_number(input longint unsigned value);
		string digits;
		digits = $sformatf("%0d", value);
		for (int i = 0; i < digits.len(); i++)
			send_char(digits[i]);
	endtask

	task automatic key_digits_random(input int n);
		repeat (n) send_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
	endtask

	// type an alarm setting and press enter; near keeps it to a few seconds
	task automatic key_alarm(input bit near);
		int pick;
		pick = near ? 0 : $urandom_range(0, 9);
		if (pick <= 4) begin
			key_number($urandom_range(1, 3));
		end else if (pick == 5) begin
			key_number($urandom);
		end else if (pick == 6) begin
			key_digits_random($urandom_range(MAX_DIGITS_DEF, MAX_DIGITS_DEF + 3));
		end else if (pick == 7) begin
			key_number(0);
		end else if (pick == 8) begin
			key_number($urandom_range(1, 2000));
		end else begin
			key_number($urandom_range(1, 9));
			send_char(CHAR_CLEAR);
			key_number($urandom_range(1, 3));
		end
		send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
	endtask

	// hold off until every result due has come, then let the pipeline empty
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
		while (due_count != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_interval(input logic [31:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		settings_used++;
	endtask

	task automatic random_phase(input logic [31:0] interval, input bit with_gaps);
		int roll;
		drain_results();
		write_interval(interval);
		gaps_on = with_gaps;
		phase_sent = 0;
		while (phase_sent < PHASE_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (run_ms < 1100) begin
				// build up elapsed time so that alarms can come due later
				if (roll < 70) begin
					tick_run($urandom_range(20, 60));
				end else if (roll < 80) begin
					key_alarm(1'b0);
				end else if (roll < 88) begin
					send_char(CHAR_PAUSE);
					tick_run($urandom_range(0, 8));
					send_char(CHAR_PAUSE);
				end else if (roll < 96) begin
					send_request(1'($urandom_range(0, 1)), 8'($urandom));
				end else begin
					key_digits_random($urandom_range(1, 4));
					send_char(CHAR_CLEAR);
					send_char(CHAR_CR);
				end
			end else begin
				if (roll < 40) begin
					tick_run($urandom_range(1, 20));
				end else if (roll < 65) begin
					key_alarm(1'b1);
					tick_run($urandom_range(1, 3));
				end else if (roll < 78) begin
					// alarm set while paused should still fire on a tick
					send_char(CHAR_PAUSE);
					tick_run($urandom_range(0, 3));
					if ($urandom_range(0, 1))
						key_alarm(1'b1);
					tick_run($urandom_range(1, 4));
					send_char(CHAR_PAUSE);
				end else if (roll < 86) begin
					send_request(1'($urandom_range(0, 1)), 8'($urandom));
				end else if (roll < 92) begin
					key_digits_random($urandom_range(0, 3));
					send_char(CHAR_CLEAR);
					send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
				end else if (roll < 94) begin
					send_char(CHAR_RESET);
				end else begin
					key_alarm(1'b0);
				end
			end
		end
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at the reset interval
		send_request(1'b0, 8'hFF);
		send_char(8'h00);
		send_char(CHAR_CR);
		repeat (MAX_DIGITS_DEF) send_char(CHAR_NINE);
		send_char(8'(CHAR_ZERO + 5));
		send_char(CHAR_LF);
		send_char(8'(CHAR_ZERO + 4));
		send_char(CHAR_CLEAR);
		send_char(CHAR_ZERO);
		send_char(CHAR_CR);
		send_char(CHAR_PAUSE);
		send_request(1'b0, 8'h00);
		send_char(CHAR_PAUSE);
		send_char(CHAR_RESET);
		drain_results();
		write_interval('0);
		send_char(8'(CHAR_ZERO + 1));
		send_char(CHAR_CR);
		tick_run(3);

		random_phase(32'd1, 1'b1);
		random_phase($urandom_range(2, 40), 1'b1);
		random_phase(32'hFFFF_FFFF, 1'b1);
		random_phase('0, 1'b0);
		random_phase(INTERVAL_RESET, 1'b1);
		random_phase($urandom_range(3, 15), 1'b1);

		drain_results();
		$display("run covered %0d requests under %0d report interval settings",
			sent_total, settings_used);
		$display("%0d results compared, %0d of them alarm events", results_seen, alarms_seen);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
